/* rtl/bfra_pkg.sv */
// ----------------------------------------------------------------------------
// bfra_pkg
// Types and constants shared by the bit field record access controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package bfra_pkg;

	typedef enum logic [2:0] {
		OP_LOAD_BYTE,
		OP_READ_BYTE,
		OP_READ_FIELD,
		OP_WRITE_FIELD,
		OP_READ_CHARS,
		OP_COUNT_ZEROS,
		OP_EMPTY_TEST
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOADB,
		ST_RDB_ISSUE,
		ST_RDB_WAIT,
		ST_FETCH,
		ST_LOAD,
		ST_BIT,
		ST_EMPTY_FETCH,
		ST_EMPTY_LOAD,
		ST_FINISH,
		ST_FAIL,
		ST_BAD
	} state_t;

	typedef enum logic [2:0] {
		PUSH_CHAR,
		PUSH_DONE,
		PUSH_FAIL,
		PUSH_BAD,
		PUSH_LOADB,
		PUSH_BYTE,
		PUSH_EMPTY_YES,
		PUSH_EMPTY_NO
	} push_kind_t;

	typedef struct packed {
		logic       start;
		logic       mem_rd_pos;
		logic       mem_rd_idx;
		logic       load_byte;
		logic       step;
		logic       empty_next;
		logic       wr_byte;
		logic       push;
		push_kind_t kind;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic rem_zero;
		logic rem_one;
		logic in_bounds;
		logic grp_last;
		logic cut;
		logic byte_end;
		logic byte_nz;
		logic out_free;
		logic wide;
		logic bidx_ok;
	} status_t;

	localparam logic [5:0] LEN_RESET  = 6'd32;
	localparam logic [5:0] CHAR_CAP   = 6'd51;
	localparam logic [8:0] FIELD_MAX  = 9'd32;
	localparam logic [4:0] CODE_SPACE = 5'd27;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] MSB_MASK   = 8'h80;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;

endpackage

/* rtl/bfra_ctrl.sv */
// ----------------------------------------------------------------------------
// bfra_ctrl
// Sequencer: decodes the request and steps the datapath byte by byte and
// bit by bit, holding where a result cannot yet be pushed.
// ----------------------------------------------------------------------------
module bfra_ctrl
	import bfra_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   is_chars;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign is_chars = (st.op == OP_READ_CHARS);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.kind = PUSH_BAD;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (st.op)
					OP_LOAD_BYTE:   state_d = ST_LOADB;
					OP_READ_BYTE:   state_d = st.bidx_ok ? ST_RDB_ISSUE : ST_BAD;
					OP_READ_FIELD:  state_d = st.wide ? ST_FAIL : ST_FETCH;
					OP_WRITE_FIELD: state_d = st.wide ? ST_FAIL : ST_FETCH;
					OP_READ_CHARS:  state_d = ST_FETCH;
					OP_COUNT_ZEROS: state_d = ST_FETCH;
					OP_EMPTY_TEST:  state_d = ST_EMPTY_FETCH;
					default:        state_d = ST_BAD;
				endcase
			end
			ST_LOADB: begin
				if (st.out_free) begin
					cmd.wr_byte = 1'b1;
					cmd.push    = 1'b1;
					cmd.kind    = PUSH_LOADB;
					state_d     = ST_IDLE;
				end
			end
			ST_RDB_ISSUE: begin
				cmd.mem_rd_idx = 1'b1;
				state_d        = ST_RDB_WAIT;
			end
			ST_RDB_WAIT: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					cmd.kind = PUSH_BYTE;
					state_d  = ST_IDLE;
				end
			end
			ST_FETCH: begin
				if (st.rem_zero) begin
					state_d = ST_FINISH;
				end else if (!st.in_bounds) begin
					state_d = ST_FAIL;
				end else begin
					cmd.mem_rd_pos = 1'b1;
					state_d        = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_byte = 1'b1;
				state_d       = ST_BIT;
			end
			ST_BIT: begin
				if (is_chars && st.grp_last && st.cut) begin
					state_d = ST_FINISH;
				end else if (!(is_chars && st.grp_last && !st.out_free)) begin
					cmd.step = 1'b1;
					if (is_chars && st.grp_last) begin
						cmd.push = 1'b1;
						cmd.kind = PUSH_CHAR;
					end
					if (st.rem_one) begin
						state_d = ST_FINISH;
					end else if (st.byte_end) begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_EMPTY_FETCH: begin
				if (!st.in_bounds) begin
					if (st.out_free) begin
						cmd.push = 1'b1;
						cmd.kind = PUSH_EMPTY_YES;
						state_d  = ST_IDLE;
					end
				end else begin
					cmd.mem_rd_pos = 1'b1;
					state_d        = ST_EMPTY_LOAD;
				end
			end
			ST_EMPTY_LOAD: begin
				if (st.byte_nz) begin
					if (st.out_free) begin
						cmd.push = 1'b1;
						cmd.kind = PUSH_EMPTY_NO;
						state_d  = ST_IDLE;
					end
				end else begin
					cmd.empty_next = 1'b1;
					state_d        = ST_EMPTY_FETCH;
				end
			end
			ST_FINISH: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					cmd.kind = PUSH_DONE;
					state_d  = ST_IDLE;
				end
			end
			ST_FAIL: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					cmd.kind = PUSH_FAIL;
					state_d  = ST_IDLE;
				end
			end
			ST_BAD: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					cmd.kind = PUSH_BAD;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/bfra_datapath.sv */
// ----------------------------------------------------------------------------
// bfra_datapath
// Record store, bit position and count registers, accumulator, char decode
// and the result register toward the output channel.
// ----------------------------------------------------------------------------
module bfra_datapath
	import bfra_pkg::*;
#(
	parameter int RECORD_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     st,
	input  logic [2:0]  in_opcode,
	input  logic [4:0]  in_byte_index,
	input  logic [7:0]  in_byte_value,
	input  logic [8:0]  in_start_bit,
	input  logic [8:0]  in_nbits,
	input  logic [31:0] in_write_value,
	input  logic [7:0]  in_max_chars,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_result_value,
	output logic [8:0]  out_next_bit,
	output logic        out_ok,
	output logic        out_last
);

	localparam int AW         = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam int TOTAL_BITS = RECORD_BYTES * 8;

	logic [7:0]              mem [RECORD_BYTES];
	logic [RECORD_BYTES-1:0] vld_q;
	logic [7:0]              rdata_q;
	logic                    rvld_q;

	logic [5:0]  len_q;
	op_t         op_q;
	logic [8:0]  pos_q;
	logic [8:0]  rem_q;
	logic [31:0] acc_q;
	logic [31:0] wsh_q;
	logic [2:0]  grp_q;
	logic [5:0]  n_q;
	logic [5:0]  cap_q;
	logic        okf_q;
	logic        wide_q;
	logic [4:0]  bidx_q;
	logic [7:0]  bval_q;
	logic [7:0]  byte_q;

	logic        ovalid_q;
	logic [31:0] oval_q;
	logic [8:0]  onext_q;
	logic        ook_q;
	logic        olast_q;

	logic [15:0]   pos_bnum, idx_bnum;
	logic [AW-1:0] pos_addr, idx_addr, rd_addr, wr_addr;
	logic          rd_en, wr_en;
	logic [7:0]    wr_data;
	logic [7:0]    mem_out;
	logic [7:0]    bmask;
	logic          cur_bit;
	logic          wbit;
	logic [7:0]    new_byte;
	logic [4:0]    new5;
	logic [7:0]    ch;
	logic          bidx_ok;
	logic          out_free;
	logic          zero_over;
	logic          scan_from_zero;
	logic          zero_clamp;
	logic [5:0]    wshift;
	logic [5:0]    cap_in;

	logic [31:0] p_val;
	logic [8:0]  p_next;
	logic        p_ok;
	logic        p_last;

	assign pos_bnum = 16'(pos_q[8:3]);
	assign idx_bnum = 16'(bidx_q);
	assign pos_addr = pos_bnum[AW-1:0];
	assign idx_addr = idx_bnum[AW-1:0];
	assign bidx_ok  = idx_bnum < 16'(RECORD_BYTES);
	assign mem_out  = rvld_q ? rdata_q : BYTE_ZERO;
	assign out_free = !ovalid_q || out_ready;

	assign bmask    = MSB_MASK >> pos_q[2:0];
	assign cur_bit  = |(byte_q & bmask);
	assign wbit     = wsh_q[31];
	assign new_byte = wbit ? (byte_q | bmask) : (byte_q & ~bmask);
	assign new5     = {acc_q[3:0], cur_bit};

	always_comb begin
		if (new5 == 5'd0) begin
			ch = CH_AT;
		end else if (new5 == CODE_SPACE) begin
			ch = CH_SPACE;
		end else begin
			ch = CH_AT + 8'(new5);
		end
	end

	assign zero_over      = 32'(in_nbits) > 32'(TOTAL_BITS);
	assign scan_from_zero = (op_t'(in_opcode) == OP_COUNT_ZEROS) ||
	                        (op_t'(in_opcode) == OP_EMPTY_TEST);
	assign zero_clamp     = (op_t'(in_opcode) == OP_COUNT_ZEROS) && zero_over;
	assign wshift         = 6'd32 - in_nbits[5:0];
	assign cap_in         = (in_max_chars < 8'(CHAR_CAP)) ? in_max_chars[5:0] : CHAR_CAP;

	// store: one write and one registered read per cycle
	assign rd_en   = cmd.mem_rd_pos || cmd.mem_rd_idx;
	assign rd_addr = cmd.mem_rd_idx ? idx_addr : pos_addr;
	assign wr_en   = (cmd.wr_byte && bidx_ok) || (cmd.step && op_q == OP_WRITE_FIELD);
	assign wr_addr = cmd.wr_byte ? idx_addr : pos_addr;
	assign wr_data = cmd.wr_byte ? bval_q : new_byte;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			rvld_q  <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			len_q    <= LEN_RESET;
			ovalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (cmd.push) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= op_t'(in_opcode);
			bidx_q <= in_byte_index;
			bval_q <= in_byte_value;
			acc_q  <= '0;
			grp_q  <= '0;
			n_q    <= '0;
			cap_q  <= cap_in;
			wsh_q  <= in_write_value << wshift;
			wide_q <= in_nbits > FIELD_MAX;
			okf_q  <= !zero_clamp;
			pos_q  <= scan_from_zero ? 9'd0 : in_start_bit;
			rem_q  <= zero_clamp ? 9'(TOTAL_BITS) : in_nbits;
		end
		if (cmd.load_byte) begin
			byte_q <= mem_out;
		end
		if (cmd.empty_next) begin
			pos_q <= pos_q + 9'd8;
		end
		if (cmd.step) begin
			pos_q <= pos_q + 9'd1;
			rem_q <= rem_q - 9'd1;
			case (op_q)
				OP_READ_FIELD: begin
					acc_q <= {acc_q[30:0], cur_bit};
				end
				OP_WRITE_FIELD: begin
					wsh_q  <= wsh_q << 1;
					byte_q <= new_byte;
				end
				OP_READ_CHARS: begin
					if (grp_q == 3'd4) begin
						acc_q <= '0;
						grp_q <= '0;
						n_q   <= n_q + 6'd1;
					end else begin
						acc_q <= 32'(new5);
						grp_q <= grp_q + 3'd1;
					end
				end
				OP_COUNT_ZEROS: begin
					acc_q <= acc_q + 32'(!cur_bit);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		p_val  = '0;
		p_next = '0;
		p_ok   = 1'b0;
		p_last = 1'b1;
		case (cmd.kind)
			PUSH_CHAR: begin
				p_val  = 32'(ch);
				p_next = pos_q + 9'd1;
				p_ok   = 1'b1;
				p_last = 1'b0;
			end
			PUSH_DONE: begin
				if (op_q == OP_READ_FIELD || op_q == OP_COUNT_ZEROS) begin
					p_val = acc_q;
				end
				p_next = pos_q;
				p_ok   = (op_q == OP_COUNT_ZEROS) ? okf_q : 1'b1;
			end
			PUSH_FAIL: begin
				p_next = pos_q;
			end
			PUSH_LOADB: begin
				p_ok = bidx_ok;
			end
			PUSH_BYTE: begin
				p_val = 32'(mem_out);
				p_ok  = 1'b1;
			end
			PUSH_EMPTY_YES: begin
				p_val = 32'd1;
				p_ok  = 1'b1;
			end
			PUSH_EMPTY_NO: begin
				p_ok = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			oval_q  <= p_val;
			onext_q <= p_next;
			ook_q   <= p_ok;
			olast_q <= p_last;
		end
	end

	assign out_valid        = ovalid_q;
	assign out_result_value = oval_q;
	assign out_next_bit     = onext_q;
	assign out_ok           = ook_q;
	assign out_last         = olast_q;

	always_comb begin
		st           = '0;
		st.op        = op_q;
		st.rem_zero  = (rem_q == 9'd0);
		st.rem_one   = (rem_q == 9'd1);
		st.in_bounds = (op_q == OP_COUNT_ZEROS) ||
		               ((pos_bnum < 16'(len_q)) && (pos_bnum < 16'(RECORD_BYTES)));
		st.grp_last  = (grp_q == 3'd4);
		st.cut       = (n_q >= cap_q);
		st.byte_end  = &pos_q[2:0];
		st.byte_nz   = (mem_out != BYTE_ZERO);
		st.out_free  = out_free;
		st.wide      = wide_q;
		st.bidx_ok   = bidx_ok;
	end

endmodule

/* rtl/bit_field_record_access_core.sv */
// ----------------------------------------------------------------------------
// bit_field_record_access_core
// Byte record with byte load/read, MSB-first bit field read/write, 5-bit
// char decode, zero bit count and empty test.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s       | in  | s_tvalid/s_tready | s_tuser opcode, s_tdata operands
//  m       | out | m_tvalid/m_tready | m_tdata result, m_tlast last result
//  cfg     | in  | cfg_valid/ready   | cfg_data record_length
//
//  Bit ops walk the store one bit a cycle, holding while a char result
//  waits for the output register, with a fetch and a load for each byte
//  touched (single store read port); the empty test fetches and loads each
//  byte scanned. Reset clears the store valid bits at once, no sweep. A new
//  request is taken while the last result waits in the output register;
//  each result stalls its request until the output register is free.
// ----------------------------------------------------------------------------
module bit_field_record_access_core
	import bfra_pkg::*;
#(
	parameter int RECORD_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// byte_index, byte_value, start_bit, nbits, write_value, max_chars, pad
	input  logic [71:0] s_tdata,
	// opcode
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_value, next_bit, ok, pad
	output logic [47:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	cmd_t        cmd;
	status_t     st;
	logic [31:0] res_value;
	logic [8:0]  res_next;
	logic        res_ok;

	assign cfg_ready = 1'b1;

	bfra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bfra_datapath #(
		.RECORD_BYTES (RECORD_BYTES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.in_opcode        (s_tuser),
		.in_byte_index    (s_tdata[4:0]),
		.in_byte_value    (s_tdata[12:5]),
		.in_start_bit     (s_tdata[21:13]),
		.in_nbits         (s_tdata[30:22]),
		.in_write_value   (s_tdata[62:31]),
		.in_max_chars     (s_tdata[70:63]),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_wdata        (cfg_data),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_result_value (res_value),
		.out_next_bit     (res_next),
		.out_ok           (res_ok),
		.out_last         (m_tlast)
	);

	assign m_tdata = {6'd0, res_ok, res_next, res_value};

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit field record access core. A queue of
// requests feeds a stream driver; every accepted request is run through a
// local mirror of the record to build the expected results, which the
// monitor compares field by field with what comes out of the block. The run
// steps through several record lengths with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import bfra_pkg::*;

	localparam int STORE_BYTES = 32;
	localparam int STUCK_LIMIT = 6000;
	localparam int PHASE_REQS  = 48;

	typedef struct {
		op_t         op;
		logic [4:0]  byte_index;
		logic [7:0]  byte_value;
		logic [8:0]  start_bit;
		logic [8:0]  nbits;
		logic [31:0] write_value;
		logic [7:0]  max_chars;
	} access_t;

	typedef struct {
		logic [31:0] value;
		logic [8:0]  next_bit;
		logic        ok;
		logic        last;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;

	access_t     pending_reqs[$];
	outcome_t    expected_outcomes[$];
	access_t     cur_req;
	int unsigned issued_reqs = 0;
	int unsigned accepted_reqs = 0;
	logic [7:0]  record_mirror[STORE_BYTES] = '{default: 8'h00};
	int unsigned length_mirror = 32;
	int unsigned mismatches = 0;
	int unsigned src_gap = 0;
	int unsigned sink_gap = 0;
	int unsigned sink_stall_left = 0;
	int unsigned stuck_cycles = 0;
	bit          src_idle_en = 1'b0;
	bit          snk_idle_en = 1'b0;
	bit          long_hold_req = 1'b0;
	bit          long_hold_taken = 1'b0;

	bit_field_record_access_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic record_bit(int unsigned pos);
		if ((pos >> 3) >= STORE_BYTES) return 1'b0;
		return record_mirror[5'(pos >> 3)][3'(7 - (pos & 7))];
	endfunction

	// expected results of one request, applied to the record mirror
	task automatic compute_outcomes(input access_t a);
		outcome_t    r;
		int unsigned lim, pos, acc, i, cap, nchar, zeros, cnt;
		bit          okf;
		lim = (length_mirror < STORE_BYTES) ? length_mirror : STORE_BYTES;
		pos = 32'(a.start_bit);
		acc = 0;
		okf = 1'b1;
		r = '{value: '0, next_bit: '0, ok: 1'b0, last: 1'b1};
		case (a.op)
			OP_LOAD_BYTE: begin
				record_mirror[a.byte_index] = a.byte_value;
				r.ok = 1'b1;
			end
			OP_READ_BYTE: begin
				r.value = 32'(record_mirror[a.byte_index]);
				r.ok = 1'b1;
			end
			OP_READ_FIELD, OP_WRITE_FIELD: begin
				if (a.nbits > 9'd32) begin
					r.next_bit = a.start_bit;
				end else begin
					for (i = 0; i < 32'(a.nbits); i++) begin
						if ((pos >> 3) >= lim) begin
							okf = 1'b0;
							break;
						end
						if (a.op == OP_READ_FIELD)
							acc = (acc << 1) | 32'(record_bit(pos));
						else
							record_mirror[5'(pos >> 3)][3'(7 - (pos & 7))] =
								a.write_value[5'(32'(a.nbits) - 1 - i)];
						pos++;
					end
					r.next_bit = 9'(pos);
					r.ok = okf;
					if (okf && a.op == OP_READ_FIELD) r.value = acc;
				end
			end
			OP_READ_CHARS: begin
				cap = (a.max_chars < 8'(CHAR_CAP)) ? 32'(a.max_chars) : 32'(CHAR_CAP);
				nchar = 0;
				for (i = 0; i < 32'(a.nbits); i++) begin
					if ((pos >> 3) >= lim) begin
						okf = 1'b0;
						break;
					end
					acc = ((acc << 1) | 32'(record_bit(pos))) & 32'h1F;
					if (i % 5 == 4) begin
						if (nchar >= cap) break;
						if (acc == 0) r.value = 32'(CH_AT);
						else if (acc == 32'(CODE_SPACE)) r.value = 32'(CH_SPACE);
						else r.value = 32'(CH_AT) + acc;   // 'A' + r - 1
						r.next_bit = 9'(pos + 1);
						r.ok = 1'b1;
						r.last = 1'b0;
						expected_outcomes.push_back(r);
						nchar++;
						acc = 0;
					end
					pos++;
				end
				r = '{value: '0, next_bit: 9'(pos), ok: okf, last: 1'b1};
			end
			OP_COUNT_ZEROS: begin
				cnt = 32'(a.nbits);
				zeros = 0;
				if (cnt > STORE_BYTES * 8) begin
					cnt = STORE_BYTES * 8;
					okf = 1'b0;
				end
				for (i = 0; i < cnt; i++)
					if (!record_bit(i)) zeros++;
				r.value = zeros;
				r.next_bit = 9'(cnt);
				r.ok = okf;
			end
			OP_EMPTY_TEST: begin
				r.value = 32'd1;
				for (i = 0; i < lim; i++)
					if (record_mirror[5'(i)] != BYTE_ZERO) begin
						r.value = '0;
						break;
					end
				r.ok = 1'b1;
			end
			default: ;
		endcase
		expected_outcomes.push_back(r);
	endtask

	task automatic note_mismatch(input string what, input outcome_t want, input outcome_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s): expected value=%h next=%0d ok=%b last=%b,",
				what, want.value, want.next_bit, want.ok, want.last);
			$display("  got value=%h next=%0d ok=%b last=%b",
				got.value, got.next_bit, got.ok, got.last);
		end
	endtask

	task automatic queue_req(input op_t op, input int unsigned bidx, input int unsigned bval,
		input int unsigned start, input int unsigned count, input logic [31:0] wval,
		input int unsigned maxc);
		access_t a;
		a.op = op;
		a.byte_index = 5'(bidx);
		a.byte_value = 8'(bval);
		a.start_bit = 9'(start);
		a.nbits = 9'(count);
		a.write_value = wval;
		a.max_chars = 8'(maxc);
		pending_reqs.push_back(a);
	endtask

	task automatic queue_random_req();
		access_t     a;
		int unsigned sel, span;
		span = ((length_mirror < STORE_BYTES) ? length_mirror : STORE_BYTES) * 8;
		sel = $urandom_range(0, 99);
		a.op = (sel < 20) ? OP_LOAD_BYTE : (sel < 28) ? OP_READ_BYTE :
			(sel < 46) ? OP_READ_FIELD : (sel < 64) ? OP_WRITE_FIELD :
			(sel < 80) ? OP_READ_CHARS : (sel < 90) ? OP_COUNT_ZEROS : OP_EMPTY_TEST;
		a.byte_index = 5'($urandom_range(0, 31));
		a.byte_value = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
		a.write_value = $urandom();
		a.start_bit = 9'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 256) :
			$urandom_range(0, span));
		sel = $urandom_range(0, 9);
		if (a.op == OP_READ_CHARS)
			a.nbits = 9'((sel < 7) ? $urandom_range(0, 40) : $urandom_range(0, 256));
		else if (a.op == OP_COUNT_ZEROS)
			a.nbits = 9'($urandom_range(0, 256));
		else
			a.nbits = 9'((sel < 8) ? $urandom_range(0, 32) : (sel < 9) ?
				$urandom_range(30, 36) : $urandom_range(33, 256));
		sel = $urandom_range(0, 9);
		a.max_chars = (sel < 5) ? 8'($urandom_range(0, 10)) : (sel < 8) ?
			8'($urandom_range(0, 255)) : 8'd255;
		pending_reqs.push_back(a);
	endtask

	task automatic write_length(input logic [5:0] len);
		@(negedge clk);
		cfg_data <= len;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		length_mirror = 32'(len);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender holds until every expected result is back, then the core idles
	task automatic drain_all();
		while (pending_reqs.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && accepted_reqs == issued_reqs) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				cur_req = pending_reqs.pop_front();
				issued_reqs++;
				s_tdata <= {1'b0, cur_req.max_chars, cur_req.write_value, cur_req.nbits,
					cur_req.start_bit, cur_req.byte_value, cur_req.byte_index};
				s_tuser <= cur_req.op;
				s_tvalid <= 1'b1;
				if (src_idle_en) src_gap = draw_gap();
			end
		end
	end

	// result sink
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_hold_req && !long_hold_taken) begin
			long_hold_taken = 1'b1;
			sink_stall_left = 400;
			m_tready <= 1'b0;
		end else if (sink_stall_left > 0) begin
			sink_stall_left--;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (snk_idle_en) sink_gap = draw_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		outcome_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				compute_outcomes(cur_req);
				accepted_reqs++;
			end
			if (m_tvalid && m_tready) begin
				got.value = m_tdata[31:0];
				got.next_bit = m_tdata[40:32];
				got.ok = m_tdata[41];
				got.last = m_tlast;
				if (expected_outcomes.size() == 0) begin
					want = '{value: '0, next_bit: '0, ok: 1'b0, last: 1'b0};
					note_mismatch("unexpected result", want, got);
				end else begin
					want = expected_outcomes.pop_front();
					if (got.value !== want.value || got.next_bit !== want.next_bit ||
						got.ok !== want.ok || got.last !== want.last)
						note_mismatch("result", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready) &&
			!(cfg_valid && cfg_ready))
			stuck_cycles++;
		else
			stuck_cycles = 0;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("[bit_field_record_access_core] ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned phase_len[7];
		phase_len = '{32, 0, 1, 31, 17, 2, 32};
		phase_len[5] = $urandom_range(2, 30);
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: field extremes, every operation, the corner cases
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		queue_req(OP_EMPTY_TEST, 0, 0, 0, 0, 0, 0);
		queue_req(OP_COUNT_ZEROS, 0, 0, 0, 256, 0, 0);
		queue_req(OP_LOAD_BYTE, 0, 255, 0, 0, 0, 0);
		queue_req(OP_LOAD_BYTE, 31, 32'(MSB_MASK), 0, 0, 0, 0);
		queue_req(OP_READ_BYTE, 0, 0, 0, 0, 0, 0);
		queue_req(OP_READ_BYTE, 31, 0, 0, 0, 0, 0);
		queue_req(OP_EMPTY_TEST, 0, 0, 0, 0, 0, 0);
		queue_req(OP_READ_FIELD, 0, 0, 0, 32, 0, 0);
		queue_req(OP_READ_FIELD, 0, 0, 256, 1, 0, 0);
		queue_req(OP_READ_FIELD, 0, 0, 256, 0, 0, 0);
		queue_req(OP_READ_FIELD, 0, 0, 4, 33, 0, 0);
		queue_req(OP_WRITE_FIELD, 0, 0, 8, 32, 32'hA5A5_A5A5, 0);
		queue_req(OP_WRITE_FIELD, 0, 0, 250, 32, 32'hFFFF_FFFF, 0);
		queue_req(OP_WRITE_FIELD, 0, 0, 0, 256, 32'hFFFF_FFFF, 0);
		queue_req(OP_WRITE_FIELD, 0, 0, 0, 0, 32'h0, 0);
		queue_req(OP_READ_FIELD, 0, 0, 240, 16, 0, 0);
		queue_req(OP_WRITE_FIELD, 0, 0, 40, 15, {17'h0, 5'd0, 5'd27, 5'd1}, 0);
		queue_req(OP_WRITE_FIELD, 0, 0, 55, 5, 32'h1F, 0);
		queue_req(OP_READ_CHARS, 0, 0, 40, 20, 0, 255);
		queue_req(OP_READ_CHARS, 0, 0, 40, 20, 0, 2);
		queue_req(OP_READ_CHARS, 0, 0, 40, 10, 0, 0);
		queue_req(OP_READ_CHARS, 0, 0, 0, 256, 0, 255);
		queue_req(OP_READ_CHARS, 0, 0, 250, 20, 0, 10);
		queue_req(OP_COUNT_ZEROS, 0, 0, 0, 0, 0, 0);
		queue_req(OP_COUNT_ZEROS, 0, 0, 0, 100, 0, 0);
		drain_all();

		foreach (phase_len[p]) begin
			write_length(6'(phase_len[p]));
			src_idle_en = (p != 2);
			snk_idle_en = (p != 2);
			if (p == 3) long_hold_req = 1'b1;
			repeat (PHASE_REQS) queue_random_req();
			drain_all();
		end

		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("[bit_field_record_access_core] OK");
		else
			$display("[bit_field_record_access_core] ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/bfra_pkg.sv
rtl/bfra_ctrl.sv
rtl/bfra_datapath.sv
rtl/bit_field_record_access_core.sv
tb/tb_top.sv
